// ===== rtl/spq_pkg.sv =====
// shared types and codes for the sorted priority queue
package spq_pkg;

    localparam int VALUE_W = 32;
    localparam int RANK_W  = 16;
    localparam int STAT_W  = 2;
    localparam int FILL_W  = 5;

    localparam logic CMD_ENQ = 1'b0;
    localparam logic CMD_DEQ = 1'b1;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic                      command;
        logic signed [VALUE_W-1:0] item_value;
        logic        [RANK_W-1:0]  item_rank;
    } item_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] out_value;
        logic        [STAT_W-1:0]  status;
        logic        [FILL_W-1:0]  fill_level;
    } result_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic        [RANK_W-1:0]  rank;
    } entry_t;

    typedef struct packed {
        logic enq;
        logic deq;
    } cell_ctl_t;

endpackage

// ===== rtl/spq_cell.sv =====
// one storage cell of the sorted chain: compares, keeps, shifts or loads
module spq_cell (
    input  logic               clk,
    input  spq_pkg::cell_ctl_t ctl,
    input  logic               occupied,
    input  logic               prev_gt,
    input  spq_pkg::entry_t    new_entry,
    input  spq_pkg::entry_t    prev_entry,
    input  spq_pkg::entry_t    next_entry,
    output spq_pkg::entry_t    entry,
    output logic               gt
);
    import spq_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;

    assign gt    = !occupied || (entry_reg.rank > new_entry.rank);
    assign entry = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.deq)
        begin
            entry_next = next_entry;
        end
        else if (ctl.enq)
        begin
            if (prev_gt)
            begin
                entry_next = prev_entry;
            end
            else if (gt)
            begin
                entry_next = new_entry;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.enq || ctl.deq)
        begin
            entry_reg <= entry_next;
        end
    end

endmodule

// ===== rtl/sorted_priority_queue.sv =====
// top level of the sorted priority queue: cell chain, count and result register
// Bounded priority queue of DEPTH entries held in a row of cells sorted by rank,
// smallest first; equal ranks leave in arrival order. Every cell compares the
// new rank at once and shifts, loads or holds, so a new item (enqueue or
// dequeue) is taken every cycle while the result register is free or being
// drained. Each item yields one result: the removed head value on a dequeue,
// and a status of empty or full when the command cannot be done. fill_level
// is the low 5 bits of the entry count after the item.
module sorted_priority_queue #(
    parameter int DEPTH = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    input  spq_pkg::item_t   item,
    output logic             result_valid,
    input  logic             result_stall,
    output spq_pkg::result_t result
);
    import spq_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             result_valid_reg;
    result_t          result_reg;
    result_t          result_next;

    logic             accept;
    logic             full;
    logic             empty;
    cell_ctl_t        ctl;
    entry_t           new_entry;
    entry_t           cell_q [DEPTH];
    logic             cell_gt [DEPTH];
    logic [CNT_W+4:0] count_ext;

    assign item_stall   = result_valid_reg && result_stall;
    assign accept       = item_valid && !item_stall;
    assign full         = (count_reg == CNT_W'(DEPTH));
    assign empty        = (count_reg == '0);
    assign ctl.enq      = accept && (item.command == CMD_ENQ) && !full;
    assign ctl.deq      = accept && (item.command == CMD_DEQ) && !empty;
    assign new_entry    = '{value: item.item_value, rank: item.item_rank};
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++)
        begin : g_cell
            logic   prev_gt;
            entry_t prev_entry;
            entry_t next_entry;

            if (g == 0)
            begin : g_first
                assign prev_gt    = 1'b0;
                assign prev_entry = '0;
            end
            else
            begin : g_mid
                assign prev_gt    = cell_gt[g-1];
                assign prev_entry = cell_q[g-1];
            end

            if (g == DEPTH - 1)
            begin : g_last
                assign next_entry = '0;
            end
            else
            begin : g_inner
                assign next_entry = cell_q[g+1];
            end

            spq_cell u_cell (
                .clk        (clk),
                .ctl        (ctl),
                .occupied   (CNT_W'(g) < count_reg),
                .prev_gt    (prev_gt),
                .new_entry  (new_entry),
                .prev_entry (prev_entry),
                .next_entry (next_entry),
                .entry      (cell_q[g]),
                .gt         (cell_gt[g])
            );
        end
    endgenerate

    always_comb
    begin
        count_next = count_reg;
        if (ctl.enq)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (ctl.deq)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    assign count_ext = {5'b0, count_next};

    always_comb
    begin
        result_next            = '0;
        result_next.fill_level = count_ext[FILL_W-1:0];
        if (item.command == CMD_DEQ)
        begin
            if (empty)
            begin
                result_next.status = ST_EMPTY;
            end
            else
            begin
                result_next.out_value = cell_q[0].value;
                result_next.status    = ST_OK;
            end
        end
        else
        begin
            result_next.status = full ? ST_FULL : ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (accept)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= result_next;
        end
    end

endmodule
